// File: hw/rtl/av_sync_master_clock_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the media sync clock
// Shared property forms; each expects clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef AV_SYNC_MASTER_CLOCK_MACROS_SVH
`define AV_SYNC_MASTER_CLOCK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AVS_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AVS_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hw/rtl/avs_pkg.sv
// ----------------------------------------------------------------------------
// avs_pkg
// Types, widths, codes and reset values shared by the media sync clock.
// ----------------------------------------------------------------------------
package avs_pkg;

  localparam int TIME_BITS      = 48;
  localparam int ANCHOR_BITS    = TIME_BITS + 2;
  localparam int DRIFT_BITS     = TIME_BITS + 4;
  localparam int WAIT_BITS      = 21;
  localparam int MAX_SLEEP_BITS = 20;
  localparam int THRESH_BITS    = 24;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [MAX_SLEEP_BITS-1:0] MAX_SLEEP_RESET = MAX_SLEEP_BITS'(50000);
  localparam logic [THRESH_BITS-1:0]    THRESH_RESET    = THRESH_BITS'(200000);
  localparam logic signed [WAIT_BITS-1:0] WAIT_MIN = {1'b1, {(WAIT_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    ACT_AUDIO_PTS = 3'd0,
    ACT_VIDEO_PTS = 3'd1,
    ACT_EXT_PTS   = 3'd2,
    ACT_SELECT    = 3'd3,
    ACT_PAUSE     = 3'd4,
    ACT_RESUME    = 3'd5,
    ACT_SEEK      = 3'd6,
    ACT_RESET     = 3'd7
  } action_t;

  localparam logic [1:0] MASTER_AUDIO = 2'd0;
  localparam logic [1:0] MASTER_VIDEO = 2'd1;
  localparam logic [1:0] MASTER_EXT   = 2'd2;
  localparam logic [1:0] SEL_INVALID  = 2'd3;

  localparam logic REG_MAX_SLEEP = 1'b0;
  localparam logic REG_THRESH    = 1'b1;

  typedef struct packed {
    logic [2:0]                  action;
    logic signed [TIME_BITS-1:0] pts_us;
    logic [TIME_BITS-1:0]        now_us;
    logic [1:0]                  master_sel;
  } in_item_t;

  typedef struct packed {
    logic signed [WAIT_BITS-1:0] wait_us;
    logic                        reanchored;
    logic signed [TIME_BITS-1:0] master_pts;
    logic                        paused;
  } out_item_t;

  // Decoded request handed from the front to the back.
  typedef struct packed {
    action_t                       op;
    logic signed [TIME_BITS-1:0]   pts;
    logic [TIME_BITS-1:0]          now;
    logic [1:0]                    sel;
    logic signed [DRIFT_BITS-1:0]  pts_minus_now;
    logic signed [ANCHOR_BITS-1:0] now_minus_pts;
  } req_t;

  typedef struct packed {
    logic [MAX_SLEEP_BITS-1:0] max_sleep;
    logic [THRESH_BITS-1:0]    threshold;
  } cfg_t;

endpackage

// File: hw/rtl/avs_front.sv
// ----------------------------------------------------------------------------
// avs_front
// Decode an incoming event and precompute the time differences that do not
// depend on clock state.
// ----------------------------------------------------------------------------
module avs_front (
  input  avs_pkg::in_item_t in_item,
  output avs_pkg::req_t     req
);
  import avs_pkg::*;

  logic signed [DRIFT_BITS-1:0]  pts_d;
  logic signed [DRIFT_BITS-1:0]  now_d;
  logic signed [ANCHOR_BITS-1:0] pts_a;
  logic signed [ANCHOR_BITS-1:0] now_a;

  always_comb begin
    pts_d = DRIFT_BITS'(in_item.pts_us);
    now_d = $signed(DRIFT_BITS'(in_item.now_us));
    pts_a = ANCHOR_BITS'(in_item.pts_us);
    now_a = $signed(ANCHOR_BITS'(in_item.now_us));

    req.op            = action_t'(in_item.action);
    req.pts           = in_item.pts_us;
    req.now           = in_item.now_us;
    req.sel           = in_item.master_sel;
    req.pts_minus_now = pts_d - now_d;
    req.now_minus_pts = now_a - pts_a;
  end

endmodule

// File: hw/rtl/avs_queue.sv
// ----------------------------------------------------------------------------
// avs_queue
// Small request queue between front and back.
// ----------------------------------------------------------------------------
module avs_queue #(
  parameter int DEPTH = avs_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  avs_pkg::req_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output avs_pkg::req_t pop_data
);
  import avs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/avs_back.sv
// ----------------------------------------------------------------------------
// avs_back
// Execute a request a cycle on the clock state when free; register the result.
// ----------------------------------------------------------------------------
module avs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  output logic               req_ready,
  input  avs_pkg::req_t      req,
  input  avs_pkg::cfg_t      cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output avs_pkg::out_item_t out_data
);
  import avs_pkg::*;

  logic [1:0]                    master_r,     master_nxt;
  logic signed [TIME_BITS-1:0]   last_audio_r, last_audio_nxt;
  logic signed [TIME_BITS-1:0]   last_video_r, last_video_nxt;
  logic signed [TIME_BITS-1:0]   last_ext_r,   last_ext_nxt;
  logic signed [ANCHOR_BITS-1:0] anchor_r,     anchor_nxt;
  logic [TIME_BITS-1:0]          paused_tot_r, paused_tot_nxt;
  logic [TIME_BITS-1:0]          pause_start_r, pause_start_nxt;
  logic                          paused_r,     paused_nxt;
  logic                          first_audio_r, first_audio_nxt;
  logic                          first_video_r, first_video_nxt;
  logic                          out_valid_r;
  out_item_t                     out_data_r,   out_data_nxt;

  logic                          pop;
  logic                          is_video;
  logic                          first_hit;
  logic                          master_hit;
  logic signed [DRIFT_BITS-1:0]  drift;
  logic signed [DRIFT_BITS-1:0]  paused_ext;
  logic signed [DRIFT_BITS-1:0]  max_ext;
  logic [DRIFT_BITS-1:0]         mag;
  logic                          over;
  logic signed [WAIT_BITS-1:0]   clamped;
  logic signed [TIME_BITS-1:0]   lp_sel;
  logic signed [ANCHOR_BITS-1:0] sel_anchor;
  logic signed [WAIT_BITS-1:0]   wait_v;
  logic                          re_v;

  assign pop       = req_valid && (!out_valid_r || out_ready);
  assign req_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Drift of a master pts: pts - now + paused_total + anchor.
  always_comb begin
    paused_ext = $signed(DRIFT_BITS'(paused_tot_r));
    drift      = req.pts_minus_now + paused_ext + DRIFT_BITS'(anchor_r);
    mag        = drift[DRIFT_BITS-1] ? -drift : drift;
    over       = mag > DRIFT_BITS'(cfg.threshold);
    max_ext    = $signed(DRIFT_BITS'(cfg.max_sleep));
    if (drift > max_ext) begin
      clamped = max_ext[WAIT_BITS-1:0];
    end else if (drift < DRIFT_BITS'(WAIT_MIN)) begin
      clamped = WAIT_MIN;
    end else begin
      clamped = drift[WAIT_BITS-1:0];
    end
  end

  // Anchor for a master switch onto a stream with a recorded pts.
  always_comb begin
    case (req.sel)
      MASTER_AUDIO: lp_sel = last_audio_r;
      MASTER_VIDEO: lp_sel = last_video_r;
      default:      lp_sel = last_ext_r;
    endcase
    sel_anchor = $signed(ANCHOR_BITS'(req.now)) - ANCHOR_BITS'(lp_sel);
  end

  always_comb begin
    master_nxt      = master_r;
    last_audio_nxt  = last_audio_r;
    last_video_nxt  = last_video_r;
    last_ext_nxt    = last_ext_r;
    anchor_nxt      = anchor_r;
    paused_tot_nxt  = paused_tot_r;
    pause_start_nxt = pause_start_r;
    paused_nxt      = paused_r;
    first_audio_nxt = first_audio_r;
    first_video_nxt = first_video_r;
    wait_v          = '0;
    re_v            = 1'b0;

    is_video   = (req.op == ACT_VIDEO_PTS);
    first_hit  = is_video ? first_video_r : first_audio_r;
    master_hit = (master_r == (is_video ? MASTER_VIDEO : MASTER_AUDIO));

    case (req.op)
      ACT_AUDIO_PTS, ACT_VIDEO_PTS: begin
        if (is_video) begin
          last_video_nxt  = req.pts;
          first_video_nxt = 1'b0;
        end else begin
          last_audio_nxt  = req.pts;
          first_audio_nxt = 1'b0;
        end
        if (first_hit) begin
          if (master_hit) begin
            anchor_nxt     = req.now_minus_pts;
            paused_tot_nxt = '0;
            paused_nxt     = 1'b0;
          end
        end else if (master_hit) begin
          if (over) begin
            anchor_nxt     = req.now_minus_pts;
            paused_tot_nxt = '0;
            re_v           = 1'b1;
          end else begin
            wait_v = clamped;
          end
        end
      end
      ACT_EXT_PTS: begin
        last_ext_nxt = req.pts;
        if (master_r == MASTER_EXT) begin
          anchor_nxt     = req.now_minus_pts;
          paused_tot_nxt = '0;
          paused_nxt     = 1'b0;
        end
      end
      ACT_SELECT: begin
        if (req.sel != SEL_INVALID && req.sel != master_r) begin
          master_nxt = req.sel;
          if (lp_sel != '0) begin
            anchor_nxt = sel_anchor;
          end
          paused_tot_nxt = '0;
          paused_nxt     = 1'b0;
        end
      end
      ACT_PAUSE: begin
        if (!paused_r) begin
          paused_nxt      = 1'b1;
          pause_start_nxt = req.now;
        end
      end
      ACT_RESUME: begin
        if (paused_r) begin
          paused_nxt     = 1'b0;
          paused_tot_nxt = paused_tot_r + (req.now - pause_start_r);
        end
      end
      ACT_SEEK: begin
        anchor_nxt      = req.now_minus_pts;
        paused_tot_nxt  = '0;
        paused_nxt      = 1'b0;
        last_audio_nxt  = req.pts;
        last_video_nxt  = req.pts;
        last_ext_nxt    = req.pts;
        first_audio_nxt = 1'b0;
        first_video_nxt = 1'b0;
      end
      ACT_RESET: begin
        master_nxt      = MASTER_AUDIO;
        last_audio_nxt  = '0;
        last_video_nxt  = '0;
        last_ext_nxt    = '0;
        anchor_nxt      = '0;
        paused_tot_nxt  = '0;
        pause_start_nxt = '0;
        paused_nxt      = 1'b0;
        first_audio_nxt = 1'b1;
        first_video_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    out_data_nxt.wait_us    = wait_v;
    out_data_nxt.reanchored = re_v;
    out_data_nxt.paused     = paused_nxt;
    case (master_nxt)
      MASTER_VIDEO: out_data_nxt.master_pts = last_video_nxt;
      MASTER_EXT:   out_data_nxt.master_pts = last_ext_nxt;
      default:      out_data_nxt.master_pts = last_audio_nxt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r      <= MASTER_AUDIO;
      last_audio_r  <= '0;
      last_video_r  <= '0;
      last_ext_r    <= '0;
      anchor_r      <= '0;
      paused_tot_r  <= '0;
      pause_start_r <= '0;
      paused_r      <= 1'b0;
      first_audio_r <= 1'b1;
      first_video_r <= 1'b1;
      out_valid_r   <= 1'b0;
    end else if (pop) begin
      master_r      <= master_nxt;
      last_audio_r  <= last_audio_nxt;
      last_video_r  <= last_video_nxt;
      last_ext_r    <= last_ext_nxt;
      anchor_r      <= anchor_nxt;
      paused_tot_r  <= paused_tot_nxt;
      pause_start_r <= pause_start_nxt;
      paused_r      <= paused_nxt;
      first_audio_r <= first_audio_nxt;
      first_video_r <= first_video_nxt;
      out_valid_r   <= 1'b1;
    end else if (out_ready) begin
      out_valid_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: hw/rtl/av_sync_master_clock.sv
// ----------------------------------------------------------------------------
// av_sync_master_clock: media sync master clock
// Path: an accepted event is written into the queue slot register, then avs_back
// executes it and registers the result in its output register.
// Throughput: 1 event per cycle while out_ready stays high, set by the state update in avs_back.
// Reset: rst_n (sync, active low) clears stream state and loads default registers.
// ----------------------------------------------------------------------------
`include "av_sync_master_clock_macros.svh"

module av_sync_master_clock #(
  parameter int QUEUE_DEPTH = avs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // event channel
  input  logic               in_valid,
  output logic               in_ready,
  input  avs_pkg::in_item_t  in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output avs_pkg::out_item_t out_data,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import avs_pkg::*;

  // Register file: two words at byte offsets 0 and 4, decoded by paddr[2].
  logic [MAX_SLEEP_BITS-1:0] max_sleep_r;
  logic [THRESH_BITS-1:0]    thresh_r;
  cfg_t                      cfg;

  // Front to queue, queue to back.
  req_t front_req;
  req_t q_req;
  logic q_valid;
  logic q_ready;

  assign pready = 1'b1;

  // Write a register on the access phase of an APB write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sleep_r <= MAX_SLEEP_RESET;
      thresh_r    <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_MAX_SLEEP: max_sleep_r <= pwdata[MAX_SLEEP_BITS-1:0];
        REG_THRESH:    thresh_r    <= pwdata[THRESH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the selected register, zero-extended.
  always_comb begin
    case (paddr[2])
      REG_MAX_SLEEP: prdata = 32'(max_sleep_r);
      REG_THRESH:    prdata = 32'(thresh_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.max_sleep = max_sleep_r;
  assign cfg.threshold = thresh_r;

  // Front: decode the event and form pts - now and now - pts up front, so the
  // back only adds the stateful terms.
  avs_front u_front (
    .in_item (in_data),
    .req     (front_req)
  );

  // Queue: in_ready follows queue space, so the front keeps accepting while a
  // finished result waits on out_ready.
  avs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_req),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_req)
  );

  // Back: apply one request to the clock state per cycle and hold the result
  // in the output register until taken.
  avs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (q_valid),
    .req_ready (q_ready),
    .req       (q_req),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A re-anchored result always reports zero wait.
  `AVS_ASSERT_IMP(a_reanchor_zero, out_valid && out_data.reanchored, out_data.wait_us == '0, "reanchor with nonzero wait")
  // A new result appears only after the back took a queued request.
  `AVS_ASSERT_IMP(a_result_from_req, $rose(out_valid), $past(q_valid), "result without request")
  // An executed pause leaves the paused flag set in its result.
  `AVS_ASSERT_NXT(a_pause_flag, q_valid && q_ready && q_req.op == ACT_PAUSE, out_valid && out_data.paused, "pause not reported")

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: media sync master clock testbench
// Drives timestamp and control requests into av_sync_master_clock and checks
// each result against a cycle-free model of the clock kept in this file, or against the table's value.
// The run starts with a table of hand-picked requests. Random traffic follows
// under several register settings: steered drifts, streams and pause/seek
// control, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb_top;
  import avs_pkg::*;

  localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up
  localparam int LONG_HOLD    = 80;    // receiver hold-off, long enough to back up the block
  localparam int DRAIN_CYCLES = 8;     // settle time after the last predicted result is seen
  localparam int PHASE_ITEMS  = 104;
  localparam logic [63:0] TIME_MASK = (64'd1 << TIME_BITS) - 64'd1;
  localparam longint WAIT_FLOOR = longint'(WAIT_MIN);

  typedef struct {
    in_item_t  ev;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  av_sync_master_clock dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Clock model state: master stream, last pts per stream, anchor and pause
  // bookkeeping. The anchor and pause sums are kept 64 bits wide; the pause sum wraps at TIME_BITS.
  logic [1:0]                clk_master;
  logic [TIME_BITS-1:0]      last_audio;
  logic [TIME_BITS-1:0]      last_video;
  logic [TIME_BITS-1:0]      last_ext;
  logic [63:0]               anchor_t;
  logic [63:0]               pause_total;
  logic [63:0]               pause_at;
  logic                      paused_f;
  logic                      audio_first;
  logic                      video_first;
  // Register copies.
  logic [MAX_SLEEP_BITS-1:0] sleep_cap;
  logic [THRESH_BITS-1:0]    jump_limit;

  out_item_t            pending_results[$];
  dir_row_t             directed_rows[$];
  logic [TIME_BITS-1:0] stream_now;   // wall clock seen by the random traffic
  int                   mismatches;
  int                   burst_left;
  bit                   steady;       // sender runs without gaps
  bit                   hold_off_req; // ask the receiver for one long stall

  // --------------------------------------------------------------------------
  // Clock model
  // --------------------------------------------------------------------------
  function automatic logic [63:0] widen(input logic [TIME_BITS-1:0] t);
    return {{(64-TIME_BITS){t[TIME_BITS-1]}}, t};
  endfunction

  function automatic void clear_clock();
    clk_master  = MASTER_AUDIO;
    last_audio  = '0;
    last_video  = '0;
    last_ext    = '0;
    anchor_t    = '0;
    pause_total = '0;
    pause_at    = '0;
    paused_f    = 1'b0;
    audio_first = 1'b1;
    video_first = 1'b1;
  endfunction

  // Advance the clock model by one request and return the result it gives.
  function automatic out_item_t clock_step(input in_item_t ev);
    logic [63:0] pts;
    logic [63:0] now;
    logic [63:0] drift;
    logic [63:0] mag;
    logic [63:0] lp;
    longint      d;
    logic [1:0]  kind;
    logic        was_first;
    logic        jumped;
    out_item_t   r;
    pts    = widen(ev.pts_us);
    now    = 64'(ev.now_us);
    d      = 0;
    jumped = 1'b0;
    case (ev.action)
      ACT_AUDIO_PTS, ACT_VIDEO_PTS: begin
        kind = (ev.action == ACT_VIDEO_PTS) ? MASTER_VIDEO : MASTER_AUDIO;
        if (kind == MASTER_VIDEO) begin
          was_first   = video_first;
          video_first = 1'b0;
          last_video  = pts[TIME_BITS-1:0];
        end else begin
          was_first   = audio_first;
          audio_first = 1'b0;
          last_audio  = pts[TIME_BITS-1:0];
        end
        if (clk_master == kind) begin
          if (was_first) begin
            // first frame of the master: anchor and drop any pause
            anchor_t    = now - pts;
            pause_total = '0;
            paused_f    = 1'b0;
          end else begin
            drift = pts - ((now - pause_total) - anchor_t);
            mag   = drift[63] ? (64'd0 - drift) : drift;
            if (mag > 64'(jump_limit)) begin
              anchor_t    = now - pts;
              pause_total = '0;
              jumped      = 1'b1;
            end else begin
              d = longint'(drift);
              if (d > longint'(sleep_cap)) d = longint'(sleep_cap);
              if (d < WAIT_FLOOR) d = WAIT_FLOOR;
            end
          end
        end
      end
      ACT_EXT_PTS: begin
        last_ext = pts[TIME_BITS-1:0];
        if (clk_master == MASTER_EXT) begin
          anchor_t    = now - pts;
          pause_total = '0;
          paused_f    = 1'b0;
        end
      end
      ACT_SELECT: begin
        if (ev.master_sel != SEL_INVALID && ev.master_sel != clk_master) begin
          case (ev.master_sel)
            MASTER_AUDIO: lp = widen(last_audio);
            MASTER_VIDEO: lp = widen(last_video);
            default:      lp = widen(last_ext);
          endcase
          clk_master = ev.master_sel;
          if (lp != 64'd0) anchor_t = now - lp;
          pause_total = '0;
          paused_f    = 1'b0;
        end
      end
      ACT_PAUSE: begin
        if (!paused_f) begin
          paused_f = 1'b1;
          pause_at = now;
        end
      end
      ACT_RESUME: begin
        if (paused_f) begin
          paused_f    = 1'b0;
          pause_total = (pause_total + (now - pause_at)) & TIME_MASK;
        end
      end
      ACT_SEEK: begin
        anchor_t    = now - pts;
        pause_total = '0;
        paused_f    = 1'b0;
        last_audio  = pts[TIME_BITS-1:0];
        last_video  = pts[TIME_BITS-1:0];
        last_ext    = pts[TIME_BITS-1:0];
        audio_first = 1'b0;
        video_first = 1'b0;
      end
      default: clear_clock();
    endcase
    r.wait_us    = WAIT_BITS'(d);
    r.reanchored = jumped;
    case (clk_master)
      MASTER_VIDEO: r.master_pts = last_video;
      MASTER_EXT:   r.master_pts = last_ext;
      default:      r.master_pts = last_audio;
    endcase
    r.paused = paused_f;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  // Pick a drift of interest and return the pts that yields it at now_v.
  function automatic logic [TIME_BITS-1:0] pts_for_drift(input logic [TIME_BITS-1:0] now_v);
    longint      dv;
    logic [63:0] media;
    case ($urandom_range(0, 5))
      0, 1: dv = longint'($urandom_range(0, 80000)) - 64'sd10000;
      2: begin
        // straddle the re-anchor threshold on either side
        dv = longint'(jump_limit) + longint'($urandom_range(0, 6)) - 64'sd3;
        if ($urandom_range(0, 1)) dv = -dv;
      end
      3: dv = longint'(sleep_cap) + longint'($urandom_range(0, 6)) - 64'sd3;
      4: begin
        // large negative drift kept below the threshold: wait saturates when the threshold allows
        if (jump_limit > THRESH_BITS'(1048576))
          dv = -longint'($urandom_range(1048577, jump_limit));
        else
          dv = -longint'($urandom_range(0, jump_limit));
      end
      default: begin
        dv = longint'(jump_limit) + 64'sd1 + longint'($urandom_range(0, 1 << 30));
        if ($urandom_range(0, 1)) dv = -dv;
      end
    endcase
    media = (64'(now_v) - pause_total) - anchor_t;
    return TIME_BITS'(media + 64'(dv));
  endfunction

  // Mostly well-formed stream traffic on a moving wall clock, some noise.
  function automatic in_item_t make_event();
    in_item_t ev;
    int       pick;
    stream_now    = stream_now + TIME_BITS'($urandom_range(0, 40000));
    ev.action     = ACT_AUDIO_PTS;
    ev.now_us     = stream_now;
    ev.master_sel = 2'($urandom_range(0, 3));
    ev.pts_us     = TIME_BITS'({$urandom, $urandom});
    pick          = $urandom_range(0, 99);
    if (pick < 5) begin
      ev.action = 3'($urandom_range(0, 7));
      ev.now_us = TIME_BITS'({$urandom, $urandom});
    end else if (pick < 55) begin
      case (clk_master)
        MASTER_VIDEO: ev.action = ACT_VIDEO_PTS;
        MASTER_EXT:   ev.action = ACT_EXT_PTS;
        default:      ev.action = ACT_AUDIO_PTS;
      endcase
      ev.pts_us = pts_for_drift(ev.now_us);
    end else if (pick < 72) begin
      ev.action = $urandom_range(0, 1) ? ACT_VIDEO_PTS : ACT_AUDIO_PTS;
      ev.pts_us = pts_for_drift(ev.now_us);
    end else if (pick < 75) begin
      ev.action = ACT_EXT_PTS;
      ev.pts_us = pts_for_drift(ev.now_us);
    end else if (pick < 82) begin
      ev.action = ACT_SELECT;
    end else if (pick < 88) begin
      ev.action = ACT_PAUSE;
    end else if (pick < 94) begin
      ev.action = ACT_RESUME;
    end else if (pick < 98) begin
      ev.action = ACT_SEEK;
      ev.pts_us = TIME_BITS'(longint'(int'($urandom)));
    end else begin
      ev.action = ACT_RESET;
    end
    return ev;
  endfunction

  function automatic out_item_t known_result(input longint w, input bit re,
                                             input longint mp, input bit p);
    out_item_t r;
    r.wait_us    = WAIT_BITS'(w);
    r.reanchored = re;
    r.master_pts = TIME_BITS'(mp);
    r.paused     = p;
    return r;
  endfunction

  task automatic add_row(input action_t a, input longint pts, input logic [TIME_BITS-1:0] now,
                         input logic [1:0] sel, input bit typed, input out_item_t want);
    dir_row_t row;
    row.ev.action     = a;
    row.ev.pts_us     = TIME_BITS'(pts);
    row.ev.now_us     = now;
    row.ev.master_sel = sel;
    row.typed         = typed;
    row.want          = want;
    directed_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Bus tasks; all called at a falling edge and return at one
  // --------------------------------------------------------------------------
  // Offer one request, predicting its result; hold valid until accepted.
  task automatic offer_request(input in_item_t ev, input bit typed, input out_item_t typed_want);
    out_item_t predicted;
    int        gap;
    predicted = clock_step(ev);
    if (typed) predicted = typed_want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                      : $urandom_range(0, 2));
      // drop valid only if the gap is real, never lower and raise in one step
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predicted);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One APB transfer, then the bus is left idle before returning.
  task automatic reg_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_check(input string what, input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] got;
    reg_access(1'b0, addr, '0, got);
    check_field(what, 64'(want), 64'(got));
  endtask

  // Write both registers (optionally with junk above the field) and read back.
  task automatic apply_setting(input logic [MAX_SLEEP_BITS-1:0] ms,
                               input logic [THRESH_BITS-1:0] th, input bit junk);
    logic [31:0] w;
    logic [31:0] unused;
    w = {(32-MAX_SLEEP_BITS)'(junk ? $urandom : 0), ms};
    reg_access(1'b1, {REG_MAX_SLEEP, 2'b00}, w, unused);
    w = {(32-THRESH_BITS)'(junk ? $urandom : 0), th};
    reg_access(1'b1, {REG_THRESH, 2'b00}, w, unused);
    sleep_cap  = ms;
    jump_limit = th;
    reg_check("sleep cap readback", {REG_MAX_SLEEP, 2'b00}, 32'(sleep_cap));
    reg_check("jump limit readback", {REG_THRESH, 2'b00}, 32'(jump_limit));
  endtask

  task automatic run_random(input int count, input int pause_at_item);
    for (int i = 0; i < count; i++) begin
      // pause the sender mid-phase until the block has fully emptied
      if (i == pause_at_item) drain_results();
      offer_request(make_event(), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side: sample at the rising edge, compare with the oldest prediction
  // --------------------------------------------------------------------------
  initial begin : result_monitor
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          check_field("wait_us", 64'(want.wait_us), 64'(out_data.wait_us));
          check_field("reanchored", 64'(want.reanchored), 64'(out_data.reanchored));
          check_field("master_pts", 64'(want.master_pts), 64'(out_data.master_pts));
          check_field("paused", 64'(want.paused), 64'(out_data.paused));
        end
      end
    end
  end

  // Receiver: stall on its own pattern, picking a new random mode when each stretch ends;
  // on request hold off for a long stretch so the block backs up.
  initial begin : result_sink
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 60);
        end
        left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: give up when no handshake happens for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("av_sync_master_clock verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    // Hold every input at a known value from time zero.
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mismatches   = 0;
    burst_left   = 0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    stream_now   = TIME_BITS'($urandom);
    clear_clock();
    sleep_cap    = MAX_SLEEP_RESET;
    jump_limit   = THRESH_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers must come out of reset at their defaults.
    reg_check("sleep cap reset", {REG_MAX_SLEEP, 2'b00}, 32'(MAX_SLEEP_RESET));
    reg_check("jump limit reset", {REG_THRESH, 2'b00}, 32'(THRESH_RESET));

    // Directed table, default registers. Audio master: first frame anchors,
    // then zero, in-range, clamped, negative and re-anchoring drifts.
    add_row(ACT_AUDIO_PTS, 1000, 5000, MASTER_AUDIO, 1'b1, known_result(0, 0, 1000, 0));
    add_row(ACT_AUDIO_PTS, 2000, 6000, MASTER_AUDIO, 1'b1, known_result(0, 0, 2000, 0));
    add_row(ACT_AUDIO_PTS, 32000, 6000, MASTER_AUDIO, 1'b1,
            known_result(30000, 0, 32000, 0));
    add_row(ACT_AUDIO_PTS, 62000, 6000, MASTER_AUDIO, 1'b1,
            known_result(50000, 0, 62000, 0));
    add_row(ACT_AUDIO_PTS, -148000, 6000, MASTER_AUDIO, 1'b1,
            known_result(-150000, 0, -148000, 0));
    add_row(ACT_AUDIO_PTS, 252000, 6000, MASTER_AUDIO, 1'b1,
            known_result(0, 1, 252000, 0));
    // Non-master streams only record their pts; extremes of pts and now.
    add_row(ACT_VIDEO_PTS, 777, 7000, MASTER_AUDIO, 1'b1, known_result(0, 0, 252000, 0));
    add_row(ACT_VIDEO_PTS, 900, 8000, MASTER_EXT, 1'b0, '0);
    add_row(ACT_EXT_PTS, 64'sh7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, SEL_INVALID, 1'b0, '0);
    // Pause and resume, each repeated to hit the no-op case.
    add_row(ACT_PAUSE, 0, 10000, MASTER_AUDIO, 1'b0, '0);
    add_row(ACT_PAUSE, 0, 11000, MASTER_AUDIO, 1'b0, '0);
    add_row(ACT_RESUME, 0, 20000, MASTER_AUDIO, 1'b0, '0);
    add_row(ACT_RESUME, 0, 21000, MASTER_AUDIO, 1'b0, '0);
    // Master switch: new, same again, and the invalid code.
    add_row(ACT_SELECT, 0, 30000, MASTER_VIDEO, 1'b0, '0);
    add_row(ACT_SELECT, 0, 31000, MASTER_VIDEO, 1'b0, '0);
    add_row(ACT_SELECT, 0, 32000, SEL_INVALID, 1'b0, '0);
    add_row(ACT_VIDEO_PTS, 12134, 40000, MASTER_AUDIO, 1'b0, '0);
    // External master at time zero with the most negative pts.
    add_row(ACT_SELECT, 0, 0, MASTER_EXT, 1'b0, '0);
    add_row(ACT_EXT_PTS, -64'sh8000_0000_0000, 0, MASTER_VIDEO, 1'b0, '0);
    add_row(ACT_SEEK, 123456, 200000, MASTER_AUDIO, 1'b0, '0);
    add_row(ACT_AUDIO_PTS, 130000, 210000, MASTER_AUDIO, 1'b0, '0);
    // Reset action, then a first master frame that clears a pause.
    add_row(ACT_RESET, 55, 220000, MASTER_VIDEO, 1'b1, known_result(0, 0, 0, 0));
    add_row(ACT_VIDEO_PTS, 4242, 1000, MASTER_AUDIO, 1'b1, known_result(0, 0, 0, 0));
    add_row(ACT_PAUSE, 0, 1500, MASTER_AUDIO, 1'b1, known_result(0, 0, 0, 1));
    add_row(ACT_AUDIO_PTS, 500, 2000, MASTER_AUDIO, 1'b1, known_result(0, 0, 500, 0));
    foreach (directed_rows[i])
      offer_request(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

    // Random traffic under the default registers.
    run_random(80, -1);

    // Further settings, each written only once the block has gone idle.
    for (int phase = 1; phase <= 5; phase++) begin
      drain_results();
      steady = 1'b0;
      case (phase)
        1: begin
          // zero clamp and zero threshold; sender without gaps
          apply_setting('0, '0, 1'b0);
          steady = 1'b1;
        end
        2: apply_setting(MAX_SLEEP_BITS'(1000000), THRESH_BITS'(10000000), 1'b0);
        3: apply_setting('1, '1, 1'b1);
        4: begin
          apply_setting(MAX_SLEEP_BITS'($urandom_range(0, 1000000)),
                        THRESH_BITS'($urandom_range(0, 10000000)), 1'b0);
          hold_off_req = 1'b1;
        end
        default: apply_setting(MAX_SLEEP_RESET, THRESH_RESET, 1'b0);
      endcase
      run_random(PHASE_ITEMS, (phase == 3) ? PHASE_ITEMS / 2 : -1);
    end

    drain_results();
    if (mismatches == 0)
      $display("av_sync_master_clock verification clean");
    else
      $display("av_sync_master_clock verification failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/avs_pkg.sv
hw/rtl/avs_front.sv
hw/rtl/avs_queue.sv
hw/rtl/avs_back.sv
hw/rtl/av_sync_master_clock.sv
tb/tb_top.sv
